@@ sv/uecu_pkg.sv @@
// Shared types, request codes and constants for the EP0 control transfer unit.
// No dependencies; used by every module of the unit.
`default_nettype none

package uecu_pkg;

  typedef enum logic [1:0] {
    FUNC_BUS_RESET = 2'd0,
    FUNC_SETUP     = 2'd1,
    FUNC_POLL      = 2'd2,
    FUNC_IN_DONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_BUS_RESET,
    CMD_START_IN,
    CMD_SET_ADDR,
    CMD_SET_CONFIG,
    CMD_SET_IDLE,
    CMD_POLL,
    CMD_IN_DONE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_SETUP    = 3'd0,
    ST_DATA_IN  = 3'd1,
    ST_IN_IDLE  = 3'd2,
    ST_STAT_OUT = 3'd3,
    ST_STAT_IN  = 3'd4,
    ST_IN_ZERO  = 3'd5
  } stage_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_WRITE_PKT = 2'd1,
    ACT_SET_ADDR  = 2'd2,
    ACT_OPEN_INT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_DEFAULT    = 2'd0,
    PH_ADDRESSED  = 2'd1,
    PH_CONFIGURED = 2'd2
  } phase_t;

  localparam logic [1:0] SRC_ZLP    = 2'd0;
  localparam logic [1:0] SRC_DEVICE = 2'd1;
  localparam logic [1:0] SRC_CONFIG = 2'd2;
  localparam logic [1:0] SRC_HID    = 2'd3;

  localparam logic [6:0] RT_STD_DEVICE  = 7'h00;
  localparam logic [6:0] RT_STD_IFACE   = 7'h01;
  localparam logic [6:0] RT_CLASS_IFACE = 7'h21;

  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] REQ_SET_IDLE          = 8'h0A;

  localparam logic [7:0] DT_DEVICE     = 8'h01;
  localparam logic [7:0] DT_CONFIG     = 8'h02;
  localparam logic [7:0] DT_HID_REPORT = 8'h22;

  localparam logic [6:0] MAX_PKT_MIN   = 7'd8;
  localparam logic [6:0] MAX_PKT_MAX   = 7'd64;
  localparam logic [6:0] MAX_PKT_RESET = 7'd64;
  localparam logic [3:0] INT_EP_RESET  = 4'd1;

  localparam logic [1:0] CFG_MAX_PACKET   = 2'd0;
  localparam logic [1:0] CFG_HID_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_INT_EP       = 2'd2;
  localparam logic [1:0] CFG_NOTIFY_EN    = 2'd3;

  // value carries transfer length, address or configuration value
  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  src;
    logic [15:0] value;
    logic [3:0]  endpoint;
  } cmd_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  pkt_source;
    logic [15:0] pkt_offset;
    logic [6:0]  pkt_length;
    logic [6:0]  dev_address;
    logic [15:0] config_number;
    phase_t      dev_phase;
    logic        notify;
    logic [3:0]  notify_endpoint;
  } result_t;

endpackage

`default_nettype wire

@@ sv/uecu_front.sv @@
// Front end: accepts events, decodes setup requests into commands and
// queues them for the back end. Depends on uecu_pkg.
`default_nettype none

module uecu_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic [1:0]     func,
  input  wire logic [7:0]     req_type,
  input  wire logic [7:0]     req_code,
  input  wire logic [15:0]    req_value,
  input  wire logic [15:0]    req_length,
  input  wire logic [3:0]     endpoint,
  input  wire logic [15:0]    hid_report_length,
  input  wire logic           cmd_pop,
  output logic                cmd_valid,
  output uecu_pkg::cmd_t      cmd
);

  uecu_pkg::cmd_t dec;
  uecu_pkg::cmd_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;
  logic [6:0]     rt;
  logic [7:0]     dtype;

  assign rt    = req_type[6:0];
  assign dtype = req_value[15:8];

  always_comb begin
    dec          = '0;
    dec.kind     = uecu_pkg::CMD_NOP;
    dec.endpoint = endpoint;
    unique case (uecu_pkg::func_t'(func))
      uecu_pkg::FUNC_BUS_RESET: dec.kind = uecu_pkg::CMD_BUS_RESET;
      uecu_pkg::FUNC_POLL:      dec.kind = uecu_pkg::CMD_POLL;
      uecu_pkg::FUNC_IN_DONE:   dec.kind = uecu_pkg::CMD_IN_DONE;
      uecu_pkg::FUNC_SETUP: begin
        if (rt == uecu_pkg::RT_STD_DEVICE) begin
          if (req_code == uecu_pkg::REQ_GET_DESCRIPTOR) begin
            if (dtype == uecu_pkg::DT_DEVICE) begin
              dec.kind  = uecu_pkg::CMD_START_IN;
              dec.src   = uecu_pkg::SRC_DEVICE;
              dec.value = req_length;
            end else if (dtype == uecu_pkg::DT_CONFIG) begin
              dec.kind  = uecu_pkg::CMD_START_IN;
              dec.src   = uecu_pkg::SRC_CONFIG;
              dec.value = req_length;
            end
          end else if (req_code == uecu_pkg::REQ_SET_ADDRESS) begin
            dec.kind  = uecu_pkg::CMD_SET_ADDR;
            dec.value = req_value;
          end else if (req_code == uecu_pkg::REQ_SET_CONFIGURATION) begin
            dec.kind  = uecu_pkg::CMD_SET_CONFIG;
            dec.value = req_value;
          end
        end else if (rt == uecu_pkg::RT_CLASS_IFACE) begin
          if (req_code == uecu_pkg::REQ_SET_IDLE) dec.kind = uecu_pkg::CMD_SET_IDLE;
        end else if (rt == uecu_pkg::RT_STD_IFACE) begin
          if (req_code == uecu_pkg::REQ_GET_DESCRIPTOR &&
              dtype == uecu_pkg::DT_HID_REPORT) begin
            dec.kind  = uecu_pkg::CMD_START_IN;
            dec.src   = uecu_pkg::SRC_HID;
            dec.value = hid_report_length;
          end
        end
      end
      default: dec.kind = uecu_pkg::CMD_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) queue[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/uecu_back.sv @@
// Back end: executes queued commands against the EP0 transfer state and
// queues one result per command. Depends on uecu_pkg.
`default_nettype none

module uecu_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire uecu_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic [6:0]     ep0_max_packet,
  input  wire logic [3:0]     int_ep_number,
  input  wire logic           notify_enable,
  input  wire logic           pop,
  output logic                empty,
  output uecu_pkg::result_t   result
);

  uecu_pkg::stage_t  stage, stage_next;
  uecu_pkg::phase_t  phase, phase_next;
  logic [15:0]       remaining, remaining_next;
  logic [15:0]       read_offset, read_offset_next;
  logic [1:0]        source_sel, source_sel_next;
  logic [15:0]       config_reg, config_reg_next;
  uecu_pkg::result_t res;
  uecu_pkg::result_t queue [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        out_count;
  logic              fire;
  logic              do_pop;
  logic [6:0]        mp;
  logic [6:0]        n;

  always_comb begin
    if (ep0_max_packet < uecu_pkg::MAX_PKT_MIN) mp = uecu_pkg::MAX_PKT_MIN;
    else if (ep0_max_packet > uecu_pkg::MAX_PKT_MAX) mp = uecu_pkg::MAX_PKT_MAX;
    else mp = ep0_max_packet;
  end

  assign n = (remaining < {9'd0, mp}) ? remaining[6:0] : mp;

  assign fire    = cmd_valid && (out_count != 2'd2);
  assign cmd_pop = fire;

  always_comb begin
    stage_next       = stage;
    phase_next       = phase;
    remaining_next   = remaining;
    read_offset_next = read_offset;
    source_sel_next  = source_sel;
    config_reg_next  = config_reg;
    res              = '0;
    res.action       = uecu_pkg::ACT_NONE;
    unique case (cmd.kind)
      uecu_pkg::CMD_BUS_RESET: begin
        remaining_next   = '0;
        read_offset_next = '0;
        source_sel_next  = '0;
        config_reg_next  = '0;
        phase_next       = uecu_pkg::PH_DEFAULT;
        stage_next       = uecu_pkg::ST_SETUP;
        res.action       = uecu_pkg::ACT_SET_ADDR;
      end
      uecu_pkg::CMD_START_IN: begin
        source_sel_next  = cmd.src;
        read_offset_next = '0;
        remaining_next   = cmd.value;
        stage_next       = uecu_pkg::ST_DATA_IN;
      end
      uecu_pkg::CMD_SET_ADDR: begin
        res.action      = uecu_pkg::ACT_SET_ADDR;
        res.dev_address = cmd.value[6:0];
        phase_next      = uecu_pkg::PH_ADDRESSED;
        stage_next      = uecu_pkg::ST_STAT_IN;
      end
      uecu_pkg::CMD_SET_CONFIG: begin
        config_reg_next     = cmd.value;
        res.action          = uecu_pkg::ACT_OPEN_INT;
        res.notify_endpoint = int_ep_number;
        phase_next          = uecu_pkg::PH_CONFIGURED;
        stage_next          = uecu_pkg::ST_STAT_IN;
      end
      uecu_pkg::CMD_SET_IDLE: stage_next = uecu_pkg::ST_STAT_IN;
      uecu_pkg::CMD_POLL: begin
        unique case (stage)
          uecu_pkg::ST_DATA_IN: begin
            res.action       = uecu_pkg::ACT_WRITE_PKT;
            res.pkt_source   = source_sel;
            res.pkt_offset   = read_offset;
            res.pkt_length   = n;
            remaining_next   = remaining - {9'd0, n};
            read_offset_next = read_offset + {9'd0, n};
            if (remaining_next != 16'd0) stage_next = uecu_pkg::ST_IN_IDLE;
            else if (n == mp) stage_next = uecu_pkg::ST_IN_ZERO;
            else stage_next = uecu_pkg::ST_STAT_OUT;
          end
          uecu_pkg::ST_STAT_OUT: stage_next = uecu_pkg::ST_SETUP;
          uecu_pkg::ST_STAT_IN: begin
            res.action     = uecu_pkg::ACT_WRITE_PKT;
            res.pkt_source = uecu_pkg::SRC_ZLP;
            stage_next     = uecu_pkg::ST_SETUP;
          end
          default: stage_next = stage;
        endcase
      end
      uecu_pkg::CMD_IN_DONE: begin
        if (remaining != 16'd0) begin
          stage_next = uecu_pkg::ST_DATA_IN;
        end else if (stage == uecu_pkg::ST_IN_ZERO) begin
          res.action     = uecu_pkg::ACT_WRITE_PKT;
          res.pkt_source = uecu_pkg::SRC_ZLP;
          stage_next     = uecu_pkg::ST_STAT_OUT;
        end
        if (notify_enable) begin
          res.notify          = 1'b1;
          res.notify_endpoint = cmd.endpoint;
        end
      end
      default: stage_next = stage;
    endcase
    res.config_number = config_reg_next;
    res.dev_phase     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= uecu_pkg::ST_SETUP;
      phase       <= uecu_pkg::PH_DEFAULT;
      remaining   <= '0;
      read_offset <= '0;
      source_sel  <= '0;
      config_reg  <= '0;
    end else if (fire) begin
      stage       <= stage_next;
      phase       <= phase_next;
      remaining   <= remaining_next;
      read_offset <= read_offset_next;
      source_sel  <= source_sel_next;
      config_reg  <= config_reg_next;
    end
  end

  assign empty  = (out_count == 2'd0);
  assign do_pop = pop && !empty;
  assign result = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (fire) queue[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (fire) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      unique case ({fire, do_pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3)
    else $error("result queue count out of range");

  a_bus_reset: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.kind == uecu_pkg::CMD_BUS_RESET |=>
      stage == uecu_pkg::ST_SETUP && remaining == 16'd0 &&
      phase == uecu_pkg::PH_DEFAULT && config_reg == 16'd0)
    else $error("bus reset did not clear transfer state");

  a_poll_conserve: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.kind == uecu_pkg::CMD_POLL && stage == uecu_pkg::ST_DATA_IN |=>
      (remaining + read_offset) == ($past(remaining) + $past(read_offset)))
    else $error("data packet lost or invented bytes");

  a_idle_pending: assert property (@(posedge clk) disable iff (rst)
    stage == uecu_pkg::ST_IN_IDLE |-> remaining != 16'd0)
    else $error("data stage idle with nothing left");

endmodule

`default_nettype wire

@@ sv/usb_ep0_control_transfer_unit.sv @@
// Top level of the EP0 control transfer unit: configuration registers,
// front end decoder and back end executor. Depends on uecu_pkg, uecu_front, uecu_back.
`default_nettype none

// Takes one event per clock while full is low (bus reset, setup, poll, IN
// complete) and gives exactly one result per event, in order. A result passes
// through the command queue and the result queue before it shows on the result
// ports; the sustained rate is one event per cycle while results are popped.
// A two-entry queue sits between the decoder and the executor and another one
// before the result ports, so either side may stall. Configuration is written
// through cfg_valid/cfg_ready, always ready, and should only change while no
// events are in flight.
module usb_ep0_control_transfer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  req_type,
  input  wire logic [7:0]  req_code,
  input  wire logic [15:0] req_value,
  input  wire logic [15:0] req_length,
  input  wire logic [3:0]  endpoint,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       action,
  output logic [1:0]       pkt_source,
  output logic [15:0]      pkt_offset,
  output logic [6:0]       pkt_length,
  output logic [6:0]       dev_address,
  output logic [15:0]      config_number,
  output logic [1:0]       dev_phase,
  output logic             notify,
  output logic [3:0]       notify_endpoint,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  logic [6:0]        ep0_max_packet;
  logic [15:0]       hid_report_length;
  logic [3:0]        int_ep_number;
  logic              notify_enable;
  logic              cmd_valid;
  logic              cmd_pop;
  uecu_pkg::cmd_t    cmd;
  uecu_pkg::result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ep0_max_packet    <= uecu_pkg::MAX_PKT_RESET;
      hid_report_length <= '0;
      int_ep_number     <= uecu_pkg::INT_EP_RESET;
      notify_enable     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        uecu_pkg::CFG_MAX_PACKET: ep0_max_packet    <= cfg_data[6:0];
        uecu_pkg::CFG_HID_LENGTH: hid_report_length <= cfg_data;
        uecu_pkg::CFG_INT_EP:     int_ep_number     <= cfg_data[3:0];
        uecu_pkg::CFG_NOTIFY_EN:  notify_enable     <= cfg_data[0];
        default:                  notify_enable     <= notify_enable;
      endcase
    end
  end

  uecu_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .func              (func),
    .req_type          (req_type),
    .req_code          (req_code),
    .req_value         (req_value),
    .req_length        (req_length),
    .endpoint          (endpoint),
    .hid_report_length (hid_report_length),
    .cmd_pop           (cmd_pop),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd)
  );

  uecu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .ep0_max_packet (ep0_max_packet),
    .int_ep_number  (int_ep_number),
    .notify_enable  (notify_enable),
    .pop            (pop),
    .empty          (empty),
    .result         (result)
  );

  assign action          = result.action;
  assign pkt_source      = result.pkt_source;
  assign pkt_offset      = result.pkt_offset;
  assign pkt_length      = result.pkt_length;
  assign dev_address     = result.dev_address;
  assign config_number   = result.config_number;
  assign dev_phase       = result.dev_phase;
  assign notify          = result.notify;
  assign notify_endpoint = result.notify_endpoint;

endmodule

`default_nettype wire
